// ===== sv/bfs_pkg.sv =====
// bfs_pkg: shared types and constants of the streaming box filter
// no dependencies; used by the channel interfaces and the top level
package bfs_pkg;

  localparam int PIX_W = 8;
  localparam int ROW_W = 12;
  localparam int WIN_W = 4;
  localparam int SUM_W = 16;
  localparam int NUM_W = SUM_W + 1;
  localparam int DEN_W = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 12;
  localparam int FW_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 2'd2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_TAIL,
    ST_DIV,
    ST_CTR,
    ST_CTRW,
    ST_OUT
  } bfs_state_t;

endpackage

// ===== sv/bfs_in_if.sv =====
// bfs_in_if: request channel carrying pixels and drain ticks
// depends on bfs_pkg
interface bfs_in_if;
  import bfs_pkg::*;
  logic valid;
  logic ready;
  logic op;
  logic [PIX_W-1:0] pixel_in;
  modport source (output valid, output op, output pixel_in, input ready);
  modport sink (input valid, input op, input pixel_in, output ready);
endinterface

// ===== sv/bfs_out_if.sv =====
// bfs_out_if: result channel carrying filtered pixels
// depends on bfs_pkg
interface bfs_out_if;
  import bfs_pkg::*;
  logic valid;
  logic ready;
  logic [PIX_W-1:0] pixel_out;
  logic frame_last;
  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface

// ===== sv/box_filter_stream.sv =====
// box_filter_stream: streaming box (mean) filter over a row store memory
// depends on bfs_pkg, bfs_in_if, bfs_out_if
//
//  channel | dir | payload               | note
//  in_ch   | in  | op, pixel_in          | pixel or drain tick
//  out_ch  | out | pixel_out, frame_last | zero or one per request
//  cfg_*   | in  | index, data           | write only, taken in idle, restarts frame
//
// a request without a result leaves the sequencer in idle; a border result reads its own
// pixel from the row store through ST_CTR and ST_CTRW; an interior result reads the s*s
// window one pixel a cycle from the row store, then runs a 17-step restoring divider
// the row store has no reset; reset clears counters and sets the configuration to 640 by 480, window 3
// while a result waits on out_ch no new request is taken
module box_filter_stream #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_WINDOW = 15
) (
  input  logic clk,
  input  logic rst_n,
  bfs_in_if.sink in_ch,
  bfs_out_if.source out_ch,
  input  logic cfg_we,
  input  logic [bfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bfs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bfs_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int SW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int DEPTH = MAX_WINDOW * MAX_WIDTH;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = WW + ROW_W;

  // row store
  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] mem_q;
  logic mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [PIX_W-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[mem_raddr];
  end

  bfs_state_t state_r, state_nxt;
  logic [FW_W-1:0] fw_r, fw_nxt;
  logic [ROW_W-1:0] fh_r, fh_nxt;
  logic [WIN_W-1:0] ws_r, ws_nxt;
  logic [CW-1:0] in_col_r, in_col_nxt, out_col_r, out_col_nxt;
  logic [ROW_W-1:0] in_row_r, in_row_nxt, out_row_r, out_row_nxt;
  logic [SW-1:0] in_slot_r, in_slot_nxt, out_slot_r, out_slot_nxt;
  logic in_done_r, in_done_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] rs_r, rs_nxt;
  logic [WIN_W-1:0] rcnt_r, rcnt_nxt, ccnt_r, ccnt_nxt;
  logic [CW-1:0] cj_r, cj_nxt, cstart_r, cstart_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic rdv_r, rdv_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [4:0] dcnt_r, dcnt_nxt;
  logic [PIX_W-1:0] pix_r, pix_nxt;
  logic flast_r, flast_nxt;

  // effective configuration
  logic [WW-1:0] w;
  logic [ROW_W-1:0] h;
  logic [WIN_W-1:0] s, e, d;
  logic [CNTW-1:0] lat;
  logic [7:0] n;
  logic [DEN_W-1:0] den;

  always_comb begin
    if (fw_r == '0) w = WW'(1);
    else if (32'(fw_r) > MAX_WIDTH) w = WW'(MAX_WIDTH);
    else w = WW'(fw_r);
    h = (fh_r == '0) ? ROW_W'(1) : fh_r;
    if (ws_r == '0) s = WIN_W'(1);
    else if (32'(ws_r) > MAX_WINDOW) s = WIN_W'(MAX_WINDOW);
    else s = ws_r;
    e = s >> 1;
    d = s - WIN_W'(1) - e;
    lat = CNTW'(d) * CNTW'(w) + CNTW'(d);
    n = 8'(s) * 8'(s);
    den = {n, 1'b0};
  end

  logic acc;
  logic restart;
  logic [CW-1:0] ic, oc;
  logic [ROW_W-1:0] ir, orow;
  logic [SW-1:0] isl, osl;
  logic [CNTW-1:0] cbase;
  logic start_emit;
  logic interior;
  logic [DEN_W:0] trial;
  logic qbit;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign out_ch.valid = (state_r == ST_OUT);
  assign out_ch.pixel_out = pix_r;
  assign out_ch.frame_last = flast_r;
  assign acc = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt = state_r;
    fw_nxt = fw_r;
    fh_nxt = fh_r;
    ws_nxt = ws_r;
    in_col_nxt = in_col_r;
    in_row_nxt = in_row_r;
    in_slot_nxt = in_slot_r;
    in_done_nxt = in_done_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    out_slot_nxt = out_slot_r;
    cnt_nxt = cnt_r;
    rs_nxt = rs_r;
    rcnt_nxt = rcnt_r;
    ccnt_nxt = ccnt_r;
    cj_nxt = cj_r;
    cstart_nxt = cstart_r;
    sum_nxt = sum_r;
    rdv_nxt = 1'b0;
    num_nxt = num_r;
    rem_nxt = rem_r;
    dcnt_nxt = dcnt_r;
    pix_nxt = pix_r;
    flast_nxt = flast_r;
    mem_we = 1'b0;
    mem_waddr = '0;
    mem_wdata = in_ch.pixel_in;
    mem_raddr = AW'(32'(out_slot_r) * MAX_WIDTH + 32'(out_col_r));
    trial = '0;
    qbit = 1'b0;
    start_emit = 1'b0;

    // a pixel after a complete frame starts a new one
    restart = acc && (in_ch.op == OP_PIXEL) && in_done_r;
    ic = restart ? '0 : in_col_r;
    ir = restart ? '0 : in_row_r;
    isl = restart ? '0 : in_slot_r;
    oc = restart ? '0 : out_col_r;
    orow = restart ? '0 : out_row_r;
    osl = restart ? '0 : out_slot_r;
    cbase = restart ? '0 : cnt_r;

    interior = (16'(s) <= 16'(w)) && (16'(s) <= 16'(h)) && (16'(orow) >= 16'(e))
      && (16'(orow) + 16'(d) <= 16'(h) - 16'd1) && (16'(oc) >= 16'(e))
      && (16'(oc) + 16'(d) <= 16'(w) - 16'd1);

    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          if (in_ch.op == OP_PIXEL) begin
            mem_we = 1'b1;
            mem_waddr = AW'(32'(isl) * MAX_WIDTH + 32'(ic));
            in_done_nxt = 1'b0;
            if ((WW'(ic) + WW'(1)) >= w) begin
              in_col_nxt = '0;
              in_row_nxt = ir + ROW_W'(1);
              in_slot_nxt = (32'(isl) == MAX_WINDOW - 1) ? '0 : isl + SW'(1);
              in_done_nxt = ((ir + ROW_W'(1)) >= h);
            end else begin
              in_col_nxt = ic + CW'(1);
              in_row_nxt = ir;
              in_slot_nxt = isl;
            end
            out_col_nxt = oc;
            out_row_nxt = orow;
            out_slot_nxt = osl;
            cnt_nxt = cbase + CNTW'(1);
            start_emit = (cbase + CNTW'(1)) > lat;
          end else begin
            start_emit = in_done_r && (cnt_r != '0);
          end
        end
        if (start_emit) begin
          flast_nxt = (orow == h - ROW_W'(1)) && (WW'(oc) == w - WW'(1));
          if (interior) begin
            rs_nxt = (osl >= SW'(e)) ? osl - SW'(e)
              : SW'({1'b0, osl} + (SW+1)'(MAX_WINDOW) - (SW+1)'(e));
            cstart_nxt = CW'(16'(oc) - 16'(e));
            cj_nxt = CW'(16'(oc) - 16'(e));
            rcnt_nxt = '0;
            ccnt_nxt = '0;
            sum_nxt = '0;
            state_nxt = ST_SUM;
          end else begin
            state_nxt = ST_CTR;
          end
        end
        // configuration writes restart the frame
        if (cfg_we && (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT
            || cfg_index == CFG_WINDOW_SIZE)) begin
          case (cfg_index)
            CFG_FRAME_WIDTH: fw_nxt = cfg_wdata[FW_W-1:0];
            CFG_FRAME_HEIGHT: fh_nxt = cfg_wdata[ROW_W-1:0];
            CFG_WINDOW_SIZE: ws_nxt = cfg_wdata[WIN_W-1:0];
            default: fw_nxt = fw_r;
          endcase
          in_col_nxt = '0;
          in_row_nxt = '0;
          in_slot_nxt = '0;
          in_done_nxt = 1'b0;
          out_col_nxt = '0;
          out_row_nxt = '0;
          out_slot_nxt = '0;
          cnt_nxt = '0;
        end
      end
      ST_SUM: begin
        mem_raddr = AW'(32'(rs_r) * MAX_WIDTH + 32'(cj_r));
        rdv_nxt = 1'b1;
        if (rdv_r) sum_nxt = sum_r + SUM_W'(mem_q);
        if (ccnt_r == s - WIN_W'(1)) begin
          ccnt_nxt = '0;
          cj_nxt = cstart_r;
          rcnt_nxt = rcnt_r + WIN_W'(1);
          rs_nxt = (32'(rs_r) == MAX_WINDOW - 1) ? '0 : rs_r + SW'(1);
          if (rcnt_r == s - WIN_W'(1)) state_nxt = ST_TAIL;
        end else begin
          ccnt_nxt = ccnt_r + WIN_W'(1);
          cj_nxt = cj_r + CW'(1);
        end
      end
      ST_TAIL: begin
        sum_nxt = sum_r + SUM_W'(mem_q);
        num_nxt = {sum_nxt, 1'b0} + NUM_W'(n);
        rem_nxt = '0;
        dcnt_nxt = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // restoring division, one quotient bit a cycle
        trial = {rem_r, num_r[NUM_W-1]};
        qbit = trial >= {1'b0, den};
        rem_nxt = qbit ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
        num_nxt = {num_r[NUM_W-2:0], qbit};
        dcnt_nxt = dcnt_r + 5'd1;
        if (dcnt_r == 5'(NUM_W - 1)) begin
          pix_nxt = num_nxt[PIX_W-1:0];
          state_nxt = ST_OUT;
        end
      end
      ST_CTR: begin
        state_nxt = ST_CTRW;
      end
      ST_CTRW: begin
        pix_nxt = mem_q;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_ch.ready) begin
          cnt_nxt = cnt_r - CNTW'(1);
          if ((WW'(out_col_r) + WW'(1)) >= w) begin
            out_col_nxt = '0;
            out_row_nxt = out_row_r + ROW_W'(1);
            out_slot_nxt = (32'(out_slot_r) == MAX_WINDOW - 1) ? '0 : out_slot_r + SW'(1);
          end else begin
            out_col_nxt = out_col_r + CW'(1);
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fw_r <= FW_W'(640);
      fh_r <= ROW_W'(480);
      ws_r <= WIN_W'(3);
      in_col_r <= '0;
      in_row_r <= '0;
      in_slot_r <= '0;
      in_done_r <= 1'b0;
      out_col_r <= '0;
      out_row_r <= '0;
      out_slot_r <= '0;
      cnt_r <= '0;
      rdv_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fw_r <= fw_nxt;
      fh_r <= fh_nxt;
      ws_r <= ws_nxt;
      in_col_r <= in_col_nxt;
      in_row_r <= in_row_nxt;
      in_slot_r <= in_slot_nxt;
      in_done_r <= in_done_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      out_slot_r <= out_slot_nxt;
      cnt_r <= cnt_nxt;
      rdv_r <= rdv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rs_r <= rs_nxt;
    rcnt_r <= rcnt_nxt;
    ccnt_r <= ccnt_nxt;
    cj_r <= cj_nxt;
    cstart_r <= cstart_nxt;
    sum_r <= sum_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    dcnt_r <= dcnt_nxt;
    pix_r <= pix_nxt;
    flast_r <= flast_nxt;
  end

  // a result is only shown while at least one pixel is pending
  a_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |-> (cnt_r != '0)) else $error("result with nothing pending");

  // a taken result returns the sequencer to idle
  a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready) |=> (state_r == ST_IDLE)) else $error("no return to idle");

  // divider runs for a bounded number of steps
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (dcnt_r < 5'(NUM_W))) else $error("divider overrun");

endmodule

// ===== test/box_filter_stream_test.sv =====
// box_filter_stream_test: self-checking bench for the streaming box filter
// depends on bfs_pkg, bfs_in_if, bfs_out_if and box_filter_stream
// a predictor follows each accepted request and every result is checked in order
`timescale 1ns / 1ps

module box_filter_stream_test;
  import bfs_pkg::*;

  localparam int MAX_W = 1024;
  localparam int MAX_S = 15;
  localparam int SETTLE = 300;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic last;
  } filt_pix_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bfs_in_if in_ch ();
  bfs_out_if out_ch ();

  box_filter_stream dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // predictor state
  logic [PIX_W-1:0] row_mem [0:MAX_S*MAX_W-1];
  int fw_reg, fh_reg, win_reg;
  int in_row, in_col, out_row, out_col;
  filt_pix_t filt_q [$];

  int errors;
  int n_pixels, n_drains, n_results, n_writes, n_requests;
  bit quiet;
  bit hold_req;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function int eff_w();
    if (fw_reg == 0) return 1;
    if (fw_reg > MAX_W) return MAX_W;
    return fw_reg;
  endfunction

  function int eff_h();
    return (fh_reg == 0) ? 1 : fh_reg;
  endfunction

  function int eff_s();
    if (win_reg == 0) return 1;
    if (win_reg > MAX_S) return MAX_S;
    return win_reg;
  endfunction

  function int mem_slot(int r, int c);
    return (r % MAX_S) * MAX_W + (c % MAX_W);
  endfunction

  function void restart_frame();
    in_row = 0;
    in_col = 0;
    out_row = 0;
    out_col = 0;
  endfunction

  function void produce_pixel(int w, int h, int s);
    int e, d, r, c, total, n, val;
    filt_pix_t res;
    e = s / 2;
    d = s - 1 - e;
    r = out_row;
    c = out_col;
    val = row_mem[mem_slot(r, c)];
    if (s <= w && s <= h && r >= e && r + d <= h - 1 && c >= e && c + d <= w - 1) begin
      total = 0;
      n = s * s;
      for (int i = r - e; i <= r + d; i++)
        for (int j = c - e; j <= c + d; j++)
          total += row_mem[mem_slot(i, j)];
      val = (2 * total + n) / (2 * n);
    end
    res.pix = val[PIX_W-1:0];
    res.last = (r == h - 1 && c == w - 1);
    filt_q.push_back(res);
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
    end
  endfunction

  function void predict_request(logic op, logic [PIX_W-1:0] px);
    int w, h, s, d, lat, p;
    w = eff_w();
    h = eff_h();
    s = eff_s();
    d = s - 1 - s / 2;
    lat = d * w + d;
    if (op == OP_PIXEL) begin
      if (in_row >= h) restart_frame();
      row_mem[mem_slot(in_row, in_col)] = px;
      p = in_row * w + in_col;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      if (out_row < h && out_row * w + out_col + lat <= p) produce_pixel(w, h, s);
    end else if (in_row >= h && out_row < h) begin
      produce_pixel(w, h, s);
    end
  endfunction

  // prediction and checking share one process so their order is fixed
  always @(posedge clk) begin
    filt_pix_t exp_pix;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) predict_request(in_ch.op, in_ch.pixel_in);
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        if (filt_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result pixel_out=%0d frame_last=%0b", $time,
                   out_ch.pixel_out, out_ch.frame_last);
        end else begin
          exp_pix = filt_q.pop_front();
          if (out_ch.pixel_out !== exp_pix.pix) begin
            errors++;
            $display("%0t: pixel_out expected %0d actual %0d", $time, exp_pix.pix,
                     out_ch.pixel_out);
          end
          if (out_ch.frame_last !== exp_pix.last) begin
            errors++;
            $display("%0t: frame_last expected %0b actual %0b", $time, exp_pix.last,
                     out_ch.frame_last);
          end
        end
      end
    end
  end

  // result side: random stalls, one long hold on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #32000000;
    $display("%0t: timeout, %0d results still awaited", $time, filt_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_req(logic op, logic [PIX_W-1:0] px);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.pixel_in <= px;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_requests++;
    if (op == OP_PIXEL) n_pixels++;
    else n_drains++;
  endtask

  task automatic drain_all();
    in_ch.valid <= 1'b0;
    while (filt_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    drain_all();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FRAME_WIDTH) fw_reg = val & 'h7ff;
    else if (idx == CFG_FRAME_HEIGHT) fh_reg = val & 'hfff;
    else if (idx == CFG_WINDOW_SIZE) win_reg = val & 'hf;
    restart_frame();
    n_writes++;
  endtask

  task automatic set_frame(int w, int h, int s);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_WINDOW_SIZE, s);
  endtask

  // one frame of pixels with occasional drain ticks, optionally cut short, then drain ticks
  task automatic send_frame(bit cut_short);
    int w, h, s, d, lat, npx, nin;
    w = eff_w();
    h = eff_h();
    s = eff_s();
    d = s - 1 - s / 2;
    lat = d * w + d;
    npx = w * h;
    nin = cut_short ? $urandom_range(1, npx) : npx;
    for (int i = 0; i < nin; i++) begin
      if ($urandom_range(0, 30) == 0) send_req(OP_DRAIN, 8'($urandom_range(0, 255)));
      case ($urandom_range(0, 9))
        0: send_req(OP_PIXEL, 8'd0);
        1: send_req(OP_PIXEL, 8'd255);
        default: send_req(OP_PIXEL, 8'($urandom_range(0, 255)));
      endcase
    end
    if (cut_short) begin
      repeat ($urandom_range(0, 3)) send_req(OP_DRAIN, 8'($urandom_range(0, 255)));
    end else begin
      repeat (((lat < npx) ? lat : npx) + $urandom_range(0, 2))
        send_req(OP_DRAIN, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_directed();
    set_frame(4, 3, 3);
    send_req(OP_PIXEL, 8'd0);
    send_req(OP_PIXEL, 8'd255);
    send_req(OP_DRAIN, 8'd255);
    for (int i = 0; i < 10; i++) send_req(OP_PIXEL, (i % 2) ? 8'd255 : 8'd1);
    repeat (7) send_req(OP_DRAIN, 8'd0);
    // new frame started by a pixel after the old frame is complete
    send_req(OP_PIXEL, 8'd128);
    send_req(OP_PIXEL, 8'd127);
    // zero-valued registers act as one
    set_frame(0, 0, 0);
    send_req(OP_PIXEL, 8'd200);
    send_req(OP_DRAIN, 8'd0);
    send_req(OP_PIXEL, 8'd55);
  endtask

  task automatic test_extremes();
    // oversized width saturates
    set_frame(2047, 1, 1);
    send_frame(1'b0);
    // window beyond the frame passes through, all via drains
    set_frame(4, 3, 9);
    send_frame(1'b0);
    set_frame(1, 30, 3);
    send_frame(1'b0);
    set_frame(16, 15, 15);
    send_frame(1'b0);
  endtask

  task automatic test_backpressure();
    set_frame(8, 8, 3);
    hold_req = 1'b1;
    send_frame(1'b0);
  endtask

  task automatic test_random(int budget);
    int stop_at;
    stop_at = n_requests + budget;
    while (n_requests < stop_at) begin
      if ($urandom_range(0, 2) != 0) begin
        write_reg(CFG_FRAME_WIDTH, ($urandom_range(0, 20) == 0) ? 0 : $urandom_range(1, 24));
        write_reg(CFG_FRAME_HEIGHT, $urandom_range(0, 12));
        write_reg(CFG_WINDOW_SIZE, $urandom_range(0, 15));
      end
      send_frame($urandom_range(0, 7) == 0);
    end
  endtask

  initial begin
    errors = 0;
    n_pixels = 0;
    n_drains = 0;
    n_results = 0;
    n_writes = 0;
    n_requests = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    fw_reg = 640;
    fh_reg = 480;
    win_reg = 3;
    restart_frame();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_FRAME_WIDTH;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.op = OP_PIXEL;
    in_ch.pixel_in = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_directed();
    test_extremes();
    test_backpressure();
    test_random(400);
    quiet = 1'b1;
    test_random(200);
    drain_all();

    $display("covered %0d pixels, %0d drain ticks, %0d register writes", n_pixels, n_drains,
             n_writes);
    $display("checked %0d filtered pixels across saturated, border and drain-only frames",
             n_results);
    if (errors == 0 && filt_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, filt_q.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
